FILE: sv/ddc_pkg.sv
// Shared types, codes and reset constants for the drive command decoder.
package ddc_pkg;

    localparam int CMD_W    = 8;
    localparam int PULSE_W  = 12;
    localparam int STEP_W   = 7;
    localparam int MOTION_W = 4;
    localparam int MOVED_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 7'd10;
    localparam logic [PULSE_W-1:0] MIN_RESET   = 12'd300;
    localparam logic [PULSE_W-1:0] MAX_RESET   = 12'd2300;
    localparam logic [PULSE_W-1:0] ANGLE_RESET = 12'd1300;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX  = 2'd2;

    // Remote command codes.
    localparam logic [CMD_W-1:0] CMD_LEFT_ON      = 8'd0;
    localparam logic [CMD_W-1:0] CMD_FWD_ON       = 8'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT_ON     = 8'd2;
    localparam logic [CMD_W-1:0] CMD_BACK_ON      = 8'd3;
    localparam logic [CMD_W-1:0] CMD_LEFT_OFF     = 8'd4;
    localparam logic [CMD_W-1:0] CMD_FWD_BACK_OFF = 8'd5;
    localparam logic [CMD_W-1:0] CMD_RIGHT_OFF    = 8'd6;
    localparam logic [CMD_W-1:0] CMD_PAN_UP       = 8'd7;
    localparam logic [CMD_W-1:0] CMD_PAN_DOWN     = 8'd8;
    localparam logic [CMD_W-1:0] CMD_TILT_DOWN    = 8'd9;
    localparam logic [CMD_W-1:0] CMD_TILT_UP      = 8'd10;
    localparam logic [CMD_W-1:0] CMD_TRACK_ON     = 8'd11;
    localparam logic [CMD_W-1:0] CMD_TRACK_OFF    = 8'd12;
    localparam logic [CMD_W-1:0] CMD_SPEED_UP     = 8'd13;
    localparam logic [CMD_W-1:0] CMD_SPEED_DOWN   = 8'd14;
    localparam logic [CMD_W-1:0] CMD_BEEP_ON      = 8'd15;
    localparam logic [CMD_W-1:0] CMD_BEEP_OFF     = 8'd16;
    localparam logic [CMD_W-1:0] CMD_AVOID_ON     = 8'd17;
    localparam logic [CMD_W-1:0] CMD_AVOID_OFF    = 8'd18;
    localparam logic [CMD_W-1:0] CMD_POWER_OFF    = 8'd19;

    // Motion codes.
    localparam logic [MOTION_W-1:0] MOT_STOP       = 4'd0;
    localparam logic [MOTION_W-1:0] MOT_FWD        = 4'd1;
    localparam logic [MOTION_W-1:0] MOT_BACK       = 4'd4;
    localparam logic [MOTION_W-1:0] MOT_LEFT       = 4'd7;
    localparam logic [MOTION_W-1:0] MOT_RIGHT      = 4'd8;
    localparam logic [MOTION_W-1:0] MOT_UNCHANGED  = 4'd9;
    // Offsets from a straight code to its left and right variants.
    localparam logic [MOTION_W-1:0] MOT_LAT_LEFT   = 4'd1;
    localparam logic [MOTION_W-1:0] MOT_LAT_RIGHT  = 4'd2;

    // Servo update codes.
    localparam logic [MOVED_W-1:0] MOVED_NONE = 2'd0;
    localparam logic [MOVED_W-1:0] MOVED_PAN  = 2'd1;
    localparam logic [MOVED_W-1:0] MOVED_TILT = 2'd2;

    typedef struct packed {
        logic [PULSE_W-1:0] servo_max;
        logic [PULSE_W-1:0] servo_min;
        logic [STEP_W-1:0]  servo_step;
    } cfg_t;

    // Packed so that the last field sits in the lowest bits.
    typedef struct packed {
        logic             link_lost;
        logic             obstacle_warning;
        logic [CMD_W-1:0] command;
    } item_t;

    typedef struct packed {
        logic                power_off;
        logic                beeper_on;
        logic                avoid_mode;
        logic                track_mode;
        logic [PULSE_W-1:0]  tilt_pulse;
        logic [PULSE_W-1:0]  pan_pulse;
        logic [MOVED_W-1:0]  servo_moved;
        logic [MOTION_W-1:0] motion;
    } result_t;

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);
    localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int CFG_DATA_W = PULSE_W;

endpackage

FILE: sv/ddc_cfg.sv
// Configuration registers for servo step and pulse limits.
module ddc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ddc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ddc_pkg::CFG_DATA_W-1:0]  wr_data,
    output ddc_pkg::cfg_t                   cfg
);
    import ddc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_SERVO_STEP: cfg_next.servo_step = wr_data[STEP_W-1:0];
                CFG_SERVO_MIN:  cfg_next.servo_min  = wr_data[PULSE_W-1:0];
                CFG_SERVO_MAX:  cfg_next.servo_max  = wr_data[PULSE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.servo_step <= STEP_RESET;
            cfg_reg.servo_min  <= MIN_RESET;
            cfg_reg.servo_max  <= MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/ddc_core.sv
// Command decode, flag state and servo stepping for one word per cycle while advance is high.
module ddc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ddc_pkg::item_t    item,
    input  ddc_pkg::cfg_t     cfg,
    output ddc_pkg::result_t  result
);
    import ddc_pkg::*;

    // drive: bit0 forward, bit1 back, bit2 left, bit3 right.
    // pend:  bit0 pan up, bit1 pan down, bit2 tilt down, bit3 tilt up.
    logic [3:0]         drive_reg, drive_next;
    logic [3:0]         pend_reg, pend_next;
    logic               track_reg, track_next;
    logic               avoid_reg, avoid_next;
    logic               beep_reg, beep_next;
    logic [PULSE_W-1:0] pan_reg, pan_next;
    logic [PULSE_W-1:0] tilt_reg, tilt_next;
    logic [MOTION_W-1:0] motion;
    logic [MOVED_W-1:0]  moved;
    logic                poff;

    function automatic logic [PULSE_W-1:0] step_up(input logic [PULSE_W-1:0] a,
                                                   input cfg_t c);
        logic [PULSE_W:0] s;
        s = {1'b0, a} + {{(PULSE_W+1-STEP_W){1'b0}}, c.servo_step};
        if (s > {1'b0, c.servo_max})
            return c.servo_max;
        return s[PULSE_W-1:0];
    endfunction

    function automatic logic [PULSE_W-1:0] step_down(input logic [PULSE_W-1:0] a,
                                                     input cfg_t c);
        logic [PULSE_W:0] lim;
        lim = {1'b0, c.servo_min} + {{(PULSE_W+1-STEP_W){1'b0}}, c.servo_step};
        if ({1'b0, a} >= lim)
            return a - {{(PULSE_W-STEP_W){1'b0}}, c.servo_step};
        return c.servo_min;
    endfunction

    function automatic logic [MOTION_W-1:0] lateral(input logic [MOTION_W-1:0] base,
                                                    input logic l, input logic r);
        if (l && !r)
            return base + MOT_LAT_LEFT;
        if (r && !l)
            return base + MOT_LAT_RIGHT;
        return base;
    endfunction

    always_comb
    begin
        drive_next = drive_reg;
        pend_next  = pend_reg;
        track_next = track_reg;
        avoid_next = avoid_reg;
        beep_next  = beep_reg;
        pan_next   = pan_reg;
        tilt_next  = tilt_reg;
        motion     = MOT_STOP;
        moved      = MOVED_NONE;
        poff       = 1'b0;

        if (item.link_lost)
        begin
            drive_next = 4'b0000;
            pend_next  = 4'b0000;
            avoid_next = 1'b0;
        end
        else
        begin
            // Every drive code but left on takes the car out of both automatic modes.
            if (item.command >= CMD_FWD_ON && item.command <= CMD_RIGHT_OFF)
            begin
                track_next = 1'b0;
                avoid_next = 1'b0;
            end
            unique case (item.command)
                CMD_LEFT_ON:      drive_next[2] = 1'b1;
                CMD_FWD_ON:       drive_next[0] = !item.obstacle_warning;
                CMD_RIGHT_ON:     drive_next[3] = 1'b1;
                CMD_BACK_ON:      drive_next[1] = 1'b1;
                CMD_LEFT_OFF:     drive_next[2] = 1'b0;
                CMD_FWD_BACK_OFF: drive_next[1:0] = 2'b00;
                CMD_RIGHT_OFF:    drive_next[3] = 1'b0;
                CMD_PAN_UP:       pend_next[0] = 1'b1;
                CMD_PAN_DOWN:     pend_next[1] = 1'b1;
                CMD_TILT_DOWN:    pend_next[2] = 1'b1;
                CMD_TILT_UP:      pend_next[3] = 1'b1;
                CMD_TRACK_ON:     track_next = 1'b1;
                CMD_TRACK_OFF:    track_next = 1'b0;
                CMD_BEEP_ON:      beep_next = 1'b1;
                CMD_BEEP_OFF:     beep_next = 1'b0;
                CMD_AVOID_ON:     avoid_next = 1'b1;
                CMD_AVOID_OFF:    avoid_next = 1'b0;
                CMD_POWER_OFF:    poff = 1'b1;
                default:          ;
            endcase

            // Drive directions win; otherwise serve one pending nudge.
            priority if (drive_next[0] && !drive_next[1])
                motion = lateral(MOT_FWD, drive_next[2], drive_next[3]);
            else if (drive_next[1] && !drive_next[0])
                motion = lateral(MOT_BACK, drive_next[2], drive_next[3]);
            else if (drive_next[2] && !drive_next[3])
                motion = MOT_LEFT;
            else if (drive_next[3] && !drive_next[2])
                motion = MOT_RIGHT;
            else if (pend_next[0])
            begin
                pend_next[0] = 1'b0;
                pan_next     = step_up(pan_reg, cfg);
                motion       = MOT_UNCHANGED;
                moved        = MOVED_PAN;
            end
            else if (pend_next[1])
            begin
                pend_next[1] = 1'b0;
                pan_next     = step_down(pan_reg, cfg);
                motion       = MOT_UNCHANGED;
                moved        = MOVED_PAN;
            end
            else if (pend_next[2])
            begin
                pend_next[2] = 1'b0;
                tilt_next    = step_down(tilt_reg, cfg);
                motion       = MOT_UNCHANGED;
                moved        = MOVED_TILT;
            end
            else if (pend_next[3])
            begin
                pend_next[3] = 1'b0;
                tilt_next    = step_up(tilt_reg, cfg);
                motion       = MOT_UNCHANGED;
                moved        = MOVED_TILT;
            end
            else
                motion = MOT_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= 4'b0000;
            pend_reg  <= 4'b0000;
            track_reg <= 1'b0;
            avoid_reg <= 1'b0;
            beep_reg  <= 1'b0;
            pan_reg   <= ANGLE_RESET;
            tilt_reg  <= ANGLE_RESET;
        end
        else if (advance)
        begin
            drive_reg <= drive_next;
            pend_reg  <= pend_next;
            track_reg <= track_next;
            avoid_reg <= avoid_next;
            beep_reg  <= beep_next;
            pan_reg   <= pan_next;
            tilt_reg  <= tilt_next;
        end
    end

    always_comb
    begin
        result.motion      = motion;
        result.servo_moved = moved;
        result.pan_pulse   = pan_next;
        result.tilt_pulse  = tilt_next;
        result.track_mode  = track_next;
        result.avoid_mode  = avoid_next;
        result.beeper_on   = beep_next;
        result.power_off   = poff;
    end

endmodule

FILE: sv/drive_command_decoder.sv
// Top level of the drive command decoder: input register, core and output register.
//
// Usage:
//   Commands arrive on the s_* stream, one word per handshake: the command code
//   with the obstacle warning and link lost flags. Every word yields exactly one
//   result word on the m_* stream with the chosen motion, the servo update code,
//   both servo pulse widths and the mode, beeper and power off flags.
//   The cfg_* channel writes servo step (index 0), minimum (1) and maximum (2)
//   pulse width; it is always ready and should be written only while idle.
// Flow:
//   An accepted word is held in the input register and decoded by the core;
//   its result is loaded into the output register once the output slot is
//   empty or being emptied. One word is taken every cycle while m_tready keeps
//   the output stream from stalling.
// Reset:
//   rst_n clears both stages, all flags and sets the pulse widths to 1300 us
//   and the configuration to step 10, minimum 300 and maximum 2300.
// Stall:
//   While m_tready is low the result holds; the input register still takes one
//   more word, then s_tready drops until the result is taken.
module drive_command_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: command[7:0], obstacle_warning[8], link_lost[9], zero fill
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ddc_pkg::S_DATA_W-1:0]    s_tdata,
    // m_tdata: motion[3:0], servo_moved[5:4], pan_pulse[17:6], tilt_pulse[29:18],
    //          track_mode[30], avoid_mode[31], beeper_on[32], power_off[33], zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ddc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ddc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ddc_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    result_t core_result;
    cfg_t    cfg;
    logic    advance;
    logic    s_fire;

    assign cfg_ready = 1'b1;

    ddc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ddc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // The held word moves on when the output slot is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= s_tdata[ITEM_W-1:0];
        if (advance)
            out_data_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-RESULT_W){1'b0}}, out_data_reg};

endmodule

FILE: sv/ddc_checker.sv
// Port-level checks for the drive command decoder and their bind.
module ddc_port_checks (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ddc_pkg::M_DATA_W-1:0]    m_tdata
);
    import ddc_pkg::*;

    result_t res;
    assign res = m_tdata[RESULT_W-1:0];

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_motion_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.motion <= MOT_UNCHANGED)
        else $error("motion code out of range");

    a_moved_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.servo_moved <= MOVED_TILT)
        else $error("servo update code out of range");

    // A servo update is reported exactly when the motion is left unchanged.
    a_moved_motion: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((res.servo_moved != MOVED_NONE) == (res.motion == MOT_UNCHANGED)))
        else $error("servo update and motion code disagree");

endmodule

bind drive_command_decoder ddc_port_checks u_ddc_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/ddc_checker.sv
// Watches the decoder's streams, predicts each result word and compares it.
`timescale 1ns / 100ps

module ddc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ddc_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ddc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ddc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              n_fail,
    output int                              n_waiting
);
    import ddc_pkg::*;

    localparam int DIR_FWD   = 0;
    localparam int DIR_BACK  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    localparam int NUDGE_PAN_UP   = 0;
    localparam int NUDGE_PAN_DN   = 1;
    localparam int NUDGE_TILT_DN  = 2;
    localparam int NUDGE_TILT_UP  = 3;

    cfg_t               servo_cfg;
    logic [3:0]         dir_flags;
    logic [3:0]         nudges;
    logic [1:0]         speed_req;
    logic               track;
    logic               avoid;
    logic               beep;
    logic [PULSE_W-1:0] pan;
    logic [PULSE_W-1:0] tilt;

    result_t expected_q[$];

    function automatic logic [PULSE_W-1:0] nudge_up(logic [PULSE_W-1:0] a);
        logic [PULSE_W:0] sum;
        sum = {1'b0, a} + {{(PULSE_W+1-STEP_W){1'b0}}, servo_cfg.servo_step};
        return (sum > {1'b0, servo_cfg.servo_max}) ? servo_cfg.servo_max : sum[PULSE_W-1:0];
    endfunction

    function automatic logic [PULSE_W-1:0] nudge_down(logic [PULSE_W-1:0] a);
        logic [PULSE_W:0] floor_val;
        floor_val = {1'b0, servo_cfg.servo_min}
                  + {{(PULSE_W+1-STEP_W){1'b0}}, servo_cfg.servo_step};
        return ({1'b0, a} >= floor_val)
            ? a - {{(PULSE_W-STEP_W){1'b0}}, servo_cfg.servo_step}
            : servo_cfg.servo_min;
    endfunction

    // A straight motion turns into its left or right variant when exactly one
    // lateral flag is set.
    function automatic logic [MOTION_W-1:0] with_lateral(logic [MOTION_W-1:0] base);
        if (dir_flags[DIR_LEFT] && !dir_flags[DIR_RIGHT])
            return base + MOT_LAT_LEFT;
        if (dir_flags[DIR_RIGHT] && !dir_flags[DIR_LEFT])
            return base + MOT_LAT_RIGHT;
        return base;
    endfunction

    task automatic decode_command(input item_t w, output result_t r);
        logic f;
        logic b;
        logic l;
        logic rt;
        r = '0;
        r.motion = MOT_STOP;
        r.servo_moved = MOVED_NONE;
        if (w.link_lost)
        begin
            dir_flags = '0;
            nudges = '0;
            speed_req = '0;
            avoid = 1'b0;
        end
        else
        begin
            if (w.command >= CMD_FWD_ON && w.command <= CMD_RIGHT_OFF)
            begin
                track = 1'b0;
                avoid = 1'b0;
            end
            case (w.command)
                CMD_LEFT_ON:      dir_flags[DIR_LEFT] = 1'b1;
                CMD_FWD_ON:       dir_flags[DIR_FWD] = !w.obstacle_warning;
                CMD_RIGHT_ON:     dir_flags[DIR_RIGHT] = 1'b1;
                CMD_BACK_ON:      dir_flags[DIR_BACK] = 1'b1;
                CMD_LEFT_OFF:     dir_flags[DIR_LEFT] = 1'b0;
                CMD_FWD_BACK_OFF:
                begin
                    dir_flags[DIR_FWD] = 1'b0;
                    dir_flags[DIR_BACK] = 1'b0;
                end
                CMD_RIGHT_OFF:    dir_flags[DIR_RIGHT] = 1'b0;
                CMD_PAN_UP:       nudges[NUDGE_PAN_UP] = 1'b1;
                CMD_PAN_DOWN:     nudges[NUDGE_PAN_DN] = 1'b1;
                CMD_TILT_DOWN:    nudges[NUDGE_TILT_DN] = 1'b1;
                CMD_TILT_UP:      nudges[NUDGE_TILT_UP] = 1'b1;
                CMD_TRACK_ON:     track = 1'b1;
                CMD_TRACK_OFF:    track = 1'b0;
                CMD_SPEED_UP:     speed_req[0] = 1'b1;
                CMD_SPEED_DOWN:   speed_req[1] = 1'b1;
                CMD_BEEP_ON:      beep = 1'b1;
                CMD_BEEP_OFF:     beep = 1'b0;
                CMD_AVOID_ON:     avoid = 1'b1;
                CMD_AVOID_OFF:    avoid = 1'b0;
                CMD_POWER_OFF:    r.power_off = 1'b1;
                default:          ;
            endcase

            f = dir_flags[DIR_FWD];
            b = dir_flags[DIR_BACK];
            l = dir_flags[DIR_LEFT];
            rt = dir_flags[DIR_RIGHT];
            if (f && !b)
                r.motion = with_lateral(MOT_FWD);
            else if (b && !f)
                r.motion = with_lateral(MOT_BACK);
            else if (l && !rt)
                r.motion = MOT_LEFT;
            else if (rt && !l)
                r.motion = MOT_RIGHT;
            else if (nudges != '0)
            begin
                // Only the highest priority nudge is served; the rest stay pending.
                r.motion = MOT_UNCHANGED;
                if (nudges[NUDGE_PAN_UP])
                begin
                    nudges[NUDGE_PAN_UP] = 1'b0;
                    pan = nudge_up(pan);
                    r.servo_moved = MOVED_PAN;
                end
                else if (nudges[NUDGE_PAN_DN])
                begin
                    nudges[NUDGE_PAN_DN] = 1'b0;
                    pan = nudge_down(pan);
                    r.servo_moved = MOVED_PAN;
                end
                else if (nudges[NUDGE_TILT_DN])
                begin
                    nudges[NUDGE_TILT_DN] = 1'b0;
                    tilt = nudge_down(tilt);
                    r.servo_moved = MOVED_TILT;
                end
                else
                begin
                    nudges[NUDGE_TILT_UP] = 1'b0;
                    tilt = nudge_up(tilt);
                    r.servo_moved = MOVED_TILT;
                end
            end
        end
        r.pan_pulse = pan;
        r.tilt_pulse = tilt;
        r.track_mode = track;
        r.avoid_mode = avoid;
        r.beeper_on = beep;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            servo_cfg.servo_step = STEP_RESET;
            servo_cfg.servo_min = MIN_RESET;
            servo_cfg.servo_max = MAX_RESET;
            dir_flags = '0;
            nudges = '0;
            speed_req = '0;
            track = 1'b0;
            avoid = 1'b0;
            beep = 1'b0;
            pan = ANGLE_RESET;
            tilt = ANGLE_RESET;
            expected_q.delete();
            n_fail = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SERVO_STEP: servo_cfg.servo_step = cfg_data[STEP_W-1:0];
                    CFG_SERVO_MIN:  servo_cfg.servo_min = cfg_data[PULSE_W-1:0];
                    CFG_SERVO_MAX:  servo_cfg.servo_max = cfg_data[PULSE_W-1:0];
                    default:        ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RESULT_W-1:0];
                if (expected_q.size() == 0)
                begin
                    $error("result word with no command waiting: %h", got);
                    n_fail++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("motion", want.motion, got.motion);
                    check_field("servo_moved", want.servo_moved, got.servo_moved);
                    check_field("pan_pulse", want.pan_pulse, got.pan_pulse);
                    check_field("tilt_pulse", want.tilt_pulse, got.tilt_pulse);
                    check_field("track_mode", want.track_mode, got.track_mode);
                    check_field("avoid_mode", want.avoid_mode, got.avoid_mode);
                    check_field("beeper_on", want.beeper_on, got.beeper_on);
                    check_field("power_off", want.power_off, got.power_off);
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_command(s_tdata[ITEM_W-1:0], want);
                expected_q.push_back(want);
            end
        end
        n_waiting = expected_q.size();
    end

endmodule

FILE: test/tb_drive_command_decoder.sv
// Testbench top for the drive command decoder: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb_drive_command_decoder;
    import ddc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PER_PHASE = 210;
    localparam int N_PHASES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int n_fail;
    int n_waiting;
    int cycle_count = 0;
    bit idle_on = 1'b1;

    drive_command_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ddc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_fail    (n_fail),
        .n_waiting (n_waiting)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: while idle_on is set, stall a random number of cycles before taking each word.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 17) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken
    // with s_tvalid still high, so a back-to-back word needs no second assignment.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic warn, logic lost);
        item_t w;
        int gap;
        w.command = cmd;
        w.obstacle_warning = warn;
        w.link_lost = lost;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'(w);
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Mostly nudges and direction changes so the servo path and the priority
    // chain are exercised; some lost links and undefined codes as noise.
    task automatic send_random_command();
        int pick;
        logic [CMD_W-1:0] cmd;
        logic lost;
        pick = $urandom_range(0, 99);
        lost = 1'b0;
        if (pick < 7)
        begin
            cmd = CMD_W'($urandom_range(0, 255));
            lost = 1'b1;
        end
        else if (pick < 14)
            cmd = CMD_W'($urandom_range(CMD_POWER_OFF + 1, 255));
        else if (pick < 46)
            cmd = CMD_W'($urandom_range(CMD_PAN_UP, CMD_TILT_UP));
        else if (pick < 60)
            cmd = CMD_W'($urandom_range(CMD_LEFT_OFF, CMD_RIGHT_OFF));
        else
            cmd = CMD_W'($urandom_range(CMD_LEFT_ON, CMD_POWER_OFF));
        send_command(cmd, ($urandom_range(0, 9) < 3), lost);
    endtask

    // Lowers s_tvalid and waits until every result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (n_waiting != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_servo_cfg(int step, int lo, int hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SERVO_STEP;
        cfg_data <= CFG_DATA_W'(step);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_SERVO_MIN;
        cfg_data <= CFG_DATA_W'(lo);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_SERVO_MAX;
        cfg_data <= CFG_DATA_W'(hi);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int step_tab[N_PHASES];
        int min_tab[N_PHASES];
        int max_tab[N_PHASES];
        int lo;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SERVO_STEP;
        cfg_data = '0;

        // Phase 0 runs on reset values; the last two settings are drawn at random.
        step_tab = '{10, 100, 1, 0, 100, 100, 37, 0};
        min_tab  = '{300, 0, 0, 1300, 2000, 4095, 1000, 0};
        max_tab  = '{2300, 4095, 4095, 1300, 500, 0, 1100, 0};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        send_command(CMD_POWER_OFF + 1, 1'b0, 1'b0);
        send_command(CMD_LEFT_ON, 1'b0, 1'b0);
        send_command(CMD_FWD_ON, 1'b0, 1'b0);
        send_command(CMD_RIGHT_ON, 1'b0, 1'b0);
        send_command(CMD_BACK_ON, 1'b0, 1'b0);
        send_command(CMD_FWD_BACK_OFF, 1'b0, 1'b0);
        send_command(CMD_LEFT_OFF, 1'b0, 1'b0);
        send_command(CMD_RIGHT_OFF, 1'b0, 1'b0);
        // Queue all four nudges behind a left turn, then release them one by one.
        send_command(CMD_LEFT_ON, 1'b0, 1'b0);
        send_command(CMD_TILT_UP, 1'b0, 1'b0);
        send_command(CMD_TILT_DOWN, 1'b0, 1'b0);
        send_command(CMD_PAN_DOWN, 1'b0, 1'b0);
        send_command(CMD_PAN_UP, 1'b0, 1'b0);
        send_command(CMD_LEFT_OFF, 1'b0, 1'b0);
        send_command(8'd200, 1'b0, 1'b0);
        send_command(CMD_SPEED_UP, 1'b0, 1'b0);
        send_command(CMD_SPEED_DOWN, 1'b0, 1'b0);
        send_command(CMD_TRACK_ON, 1'b0, 1'b0);
        send_command(CMD_AVOID_ON, 1'b0, 1'b0);
        send_command(CMD_BEEP_ON, 1'b0, 1'b0);
        send_command(CMD_POWER_OFF, 1'b0, 1'b0);
        send_command(CMD_FWD_ON, 1'b1, 1'b0);
        send_command(CMD_TRACK_ON, 1'b0, 1'b0);
        send_command(CMD_AVOID_ON, 1'b1, 1'b0);
        send_command(CMD_FWD_ON, 1'b0, 1'b0);
        send_command(8'd255, 1'b1, 1'b1);
        send_command(CMD_POWER_OFF, 1'b0, 1'b1);
        send_command(CMD_TRACK_OFF, 1'b0, 1'b0);
        send_command(CMD_BEEP_OFF, 1'b0, 1'b0);
        send_command(CMD_AVOID_OFF, 1'b0, 1'b0);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                if (p >= N_PHASES - 2)
                begin
                    lo = $urandom_range(0, 2000);
                    step_tab[p] = $urandom_range(1, 100);
                    min_tab[p] = lo;
                    max_tab[p] = $urandom_range(lo, 4095);
                end
                write_servo_cfg(step_tab[p], min_tab[p], max_tab[p]);
            end
            idle_on = (p % 3) != 2;
            repeat (RAND_PER_PHASE) send_random_command();
        end

        drain();
        repeat (10) @(negedge clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/ddc_pkg.sv
sv/ddc_cfg.sv
sv/ddc_core.sv
sv/drive_command_decoder.sv
sv/ddc_checker.sv
test/ddc_checker.sv
test/tb_drive_command_decoder.sv
